### sv/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, codes and the byte-wide CRC-32 step for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

  // Result kind codes
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION     = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  localparam int unsigned ADDR_W = 4;

  // Register reset values
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h00;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h00;
  localparam logic [7:0]  VERSION_RST     = 8'h01;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  // Header byte positions (the sync bytes are positions 0 and 1)
  localparam logic [3:0] HDR_VERSION = 4'd2;
  localparam logic [3:0] HDR_TYPE    = 4'd3;
  localparam logic [3:0] HDR_FLAGS   = 4'd4;
  localparam logic [3:0] HDR_SEQ_HI  = 4'd5;
  localparam logic [3:0] HDR_SEQ_LO  = 4'd6;
  localparam logic [3:0] HDR_LEN_HI  = 4'd7;
  localparam logic [3:0] HDR_LEN_LO  = 4'd8;

  localparam logic [1:0] CHECK_LAST = 2'd3;

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  typedef enum logic [4:0] {
    PH_HUNT0   = 5'b00001,
    PH_HUNT1   = 5'b00010,
    PH_HEADER  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/frame_deframer_crc32_check.sv
// ----------------------------------------------------------------------------
// frame_deframer_crc32_check
// Hunts for two sync bytes, parses a 9-byte header, streams payload words
// and gives a frame-good or checksum-error verdict after a reflected CRC-32.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   in       to block   in_valid/in_stall  rx_byte
//   out      from block out_valid/out_stall result_kind, data_byte, byte_index,
//                                           frame_type, frame_flags,
//                                           frame_sequence, frame_length
//   cfg      to block   APB psel/penable   paddr, pwdata, prdata
//
// One word per cycle sustained while the output is not stalled. A word sits
// in the input register, then the parser, header fields and CRC-32 update in
// a single pass into the output register. The byte-wide CRC step sets the
// longest path. Synchronous reset returns the parser to the hunt and empties
// both registers. A stalled output holds its word; the input stalls only while
// a word waits in the input register and the output cannot take a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_deframer_crc32_check (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  result_kind,
  output logic [7:0]                  data_byte,
  output logic [15:0]                 byte_index,
  output logic [7:0]                  frame_type,
  output logic [7:0]                  frame_flags,
  output logic [15:0]                 frame_sequence,
  output logic [15:0]                 frame_length,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import fdc_pkg::*;

  // configuration registers
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  exp_version;
  logic [15:0] max_payload;
  logic        cfg_write;
  logic [1:0]  cfg_sel;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  // parser state
  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_flags, held_flags_next;
  logic [15:0] held_sequence, held_sequence_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [1:0]  check_count, check_count_next;
  logic [31:0] received_check, received_check_next;
  logic [31:0] running_crc, running_crc_next;
  logic        version_bad, version_bad_next;

  // result of the current word
  logic        produce;
  logic [1:0]  res_kind;
  logic [7:0]  res_data;
  logic [15:0] res_index;
  logic [31:0] crc_step;
  logic [31:0] check_word;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      exp_version <= VERSION_RST;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_SYNC_FIRST:  sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second <= pwdata[7:0];
        REG_VERSION:     exp_version <= pwdata[7:0];
        REG_MAX_PAYLOAD: max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Return the selected register
  always_comb begin
    case (cfg_sel)
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second};
      REG_VERSION:     prdata = {24'd0, exp_version};
      REG_MAX_PAYLOAD: prdata = {16'd0, max_payload};
      default:         prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the word on accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Parser step
  // --------------------------------------------------------------------------
  assign crc_step   = crc32_byte(running_crc, s1_byte);
  assign check_word = {received_check[23:0], s1_byte};

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    held_type_next      = held_type;
    held_flags_next     = held_flags;
    held_sequence_next  = held_sequence;
    held_length_next    = held_length;
    payload_count_next  = payload_count;
    check_count_next    = check_count;
    received_check_next = received_check;
    running_crc_next    = running_crc;
    version_bad_next    = version_bad;
    produce             = 1'b0;
    res_kind            = KIND_PAYLOAD;
    res_data            = 8'd0;
    res_index           = 16'd0;

    case (phase)
      PH_HUNT1: begin
        if (s1_byte == sync_second) begin
          running_crc_next  = crc_step;
          header_count_next = HDR_VERSION;
          phase_next        = PH_HEADER;
        end else begin
          // drop back to the hunt without retesting this word
          phase_next          = PH_HUNT0;
          header_count_next   = 4'd0;
          payload_count_next  = 16'd0;
          held_length_next    = 16'd0;
          check_count_next    = 2'd0;
          received_check_next = 32'd0;
          running_crc_next    = CRC_INIT;
          version_bad_next    = 1'b0;
        end
      end

      PH_HEADER: begin
        running_crc_next = crc_step;
        case (header_count)
          HDR_VERSION: version_bad_next = (s1_byte != exp_version);
          HDR_TYPE:    held_type_next   = s1_byte;
          HDR_FLAGS:   held_flags_next  = s1_byte;
          HDR_SEQ_HI:  held_sequence_next = {s1_byte, held_sequence[7:0]};
          HDR_SEQ_LO:  held_sequence_next = {held_sequence[15:8], s1_byte};
          HDR_LEN_HI:  held_length_next = {s1_byte, held_length[7:0]};
          default:     held_length_next = {held_length[15:8], s1_byte};
        endcase
        header_count_next = header_count + 4'd1;
        if (header_count == HDR_LEN_LO) begin
          if (version_bad || (held_length_next > max_payload)) begin
            // drop the frame silently
            phase_next          = PH_HUNT0;
            header_count_next   = 4'd0;
            payload_count_next  = 16'd0;
            held_length_next    = 16'd0;
            check_count_next    = 2'd0;
            received_check_next = 32'd0;
            running_crc_next    = CRC_INIT;
            version_bad_next    = 1'b0;
          end else begin
            payload_count_next  = 16'd0;
            check_count_next    = 2'd0;
            received_check_next = 32'd0;
            phase_next = (held_length_next == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        running_crc_next   = crc_step;
        produce            = 1'b1;
        res_kind           = KIND_PAYLOAD;
        res_data           = s1_byte;
        res_index          = payload_count;
        payload_count_next = payload_count + 16'd1;
        if (payload_count_next == held_length) begin
          check_count_next    = 2'd0;
          received_check_next = 32'd0;
          phase_next          = PH_CHECK;
        end
      end

      PH_CHECK: begin
        received_check_next = check_word;
        check_count_next    = check_count + 2'd1;
        if (check_count == CHECK_LAST) begin
          produce  = 1'b1;
          res_kind = ((~running_crc) == check_word) ? KIND_GOOD : KIND_CRC_ERR;
          // back to the hunt after the verdict
          phase_next          = PH_HUNT0;
          header_count_next   = 4'd0;
          payload_count_next  = 16'd0;
          held_length_next    = 16'd0;
          check_count_next    = 2'd0;
          received_check_next = 32'd0;
          running_crc_next    = CRC_INIT;
          version_bad_next    = 1'b0;
        end
      end

      default: begin
        // hunt for the first sync byte
        if (s1_byte == sync_first) begin
          phase_next          = PH_HUNT1;
          header_count_next   = 4'd1;
          payload_count_next  = 16'd0;
          held_length_next    = 16'd0;
          check_count_next    = 2'd0;
          received_check_next = 32'd0;
          running_crc_next    = crc32_byte(CRC_INIT, s1_byte);
          version_bad_next    = 1'b0;
        end
      end
    endcase
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT0;
      header_count   <= 4'd0;
      held_type      <= 8'd0;
      held_flags     <= 8'd0;
      held_sequence  <= 16'd0;
      held_length    <= 16'd0;
      payload_count  <= 16'd0;
      check_count    <= 2'd0;
      received_check <= 32'd0;
      running_crc    <= CRC_INIT;
      version_bad    <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      held_type      <= held_type_next;
      held_flags     <= held_flags_next;
      held_sequence  <= held_sequence_next;
      held_length    <= held_length_next;
      payload_count  <= payload_count_next;
      check_count    <= check_count_next;
      received_check <= received_check_next;
      running_crc    <= running_crc_next;
      version_bad    <= version_bad_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load a new result word
  always_ff @(posedge clk) begin
    if (advance && produce) begin
      result_kind    <= res_kind;
      data_byte      <= res_data;
      byte_index     <= res_index;
      frame_type     <= held_type;
      frame_flags    <= held_flags;
      frame_sequence <= held_sequence;
      frame_length   <= held_length;
    end
  end

endmodule

`default_nettype wire
